// ----- hdl/teq_pkg.sv -----
`default_nettype none
package teq_pkg;

  // Default build sizes
  localparam int CAPACITY_DEF     = 1024;
  localparam int ELEMENT_BITS_DEF = 32;

  // Operation codes carried on the request channel
  typedef enum logic [1:0] {
    OP_PUSH_FRONT  = 2'd0,
    OP_PUSH_MIDDLE = 2'd1,
    OP_PUSH_BACK   = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // capture the item and launch ring reads
    logic execute;  // apply ring writes, pointer moves and load the result
  } cmd_t;

endpackage
`default_nettype wire

// ----- hdl/teq_ram.sv -----
`default_nettype none
module teq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/teq_ctrl.sv -----
`default_nettype none
module teq_ctrl
  import teq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   rsp_blocked;

  // Hold new items while busy or while a result is still stalled
  assign rsp_blocked = rsp_valid && rsp_stall;
  assign req_stall   = (state != S_IDLE) || rsp_blocked;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && !rsp_blocked) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = req_valid && !rsp_blocked;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State and result-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/teq_datapath.sv -----
`default_nettype none
module teq_datapath
  import teq_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic        [1:0]  operation,
  input  wire logic signed [31:0] element_value,
  input  wire logic        [9:0]  position,
  output logic signed      [31:0] read_value,
  output logic             [1:0]  status,
  output logic             [10:0] held_count
);

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW   = $clog2(HALF + 1);
  localparam int HW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > 10) ? CW : 10;
  localparam int QW   = (HW > 10) ? HW : 10;
  localparam int EB   = ELEMENT_BITS;

  // Ring slot at an offset from a head, wrapping once
  function automatic logic [AW-1:0] slot_at(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(HALF)) begin
      sum = sum - (CW+1)'(HALF);
    end
    return AW'(sum);
  endfunction

  // Ring slot just ahead of a head
  function automatic logic [AW-1:0] slot_before(logic [AW-1:0] base);
    logic [AW-1:0] res;
    if (base == '0) begin
      res = AW'(HALF - 1);
    end else begin
      res = base - AW'(1);
    end
    return res;
  endfunction

  // Ring pointers and fills
  logic [AW-1:0] front_start, front_start_next;
  logic [CW-1:0] front_used,  front_used_next;
  logic [AW-1:0] back_start,  back_start_next;
  logic [CW-1:0] back_used,   back_used_next;

  // Captured item
  op_t           op_q;
  logic [EB-1:0] val_q;
  logic          range_q;
  logic          in_front_q;

  // Ring ports
  logic          f_we, b_we;
  logic [AW-1:0] f_wa, b_wa, f_ra, b_ra;
  logic [EB-1:0] f_wd, b_wd, f_rd, b_rd;

  // Result registers
  logic [EB-1:0] rv,  rv_next;
  status_t       st,  st_next;
  logic [HW-1:0] held, held_next;
  logic [63:0]   val_sx;
  logic [63:0]   rv_wide;
  logic          full, odd;
  logic [CW-1:0] back_off;
  op_t           op_in;

  assign op_in    = op_t'(operation);
  assign held     = HW'(front_used) + HW'(back_used);
  assign full     = held >= HW'(CAPACITY);
  assign odd      = held[0];
  assign val_sx   = 64'(element_value);
  assign back_off = CW'(PW'(position) - PW'(front_used));

  // Read addresses: the indexed slot for reads, the slot that may move for pushes
  always_comb begin
    if (op_in == OP_READ) begin
      f_ra = slot_at(front_start, CW'(position));
      b_ra = slot_at(back_start, back_off);
    end else begin
      f_ra = slot_at(front_start, front_used - CW'(1));
      b_ra = back_start;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= op_in;
      val_q      <= val_sx[EB-1:0];
      range_q    <= QW'(position) >= QW'(held);
      in_front_q <= PW'(position) < PW'(front_used);
    end
  end

  // Apply the operation
  always_comb begin
    f_we             = 1'b0;
    f_wa             = slot_before(front_start);
    f_wd             = val_q;
    b_we             = 1'b0;
    b_wa             = slot_before(back_start);
    b_wd             = val_q;
    front_start_next = front_start;
    front_used_next  = front_used;
    back_start_next  = back_start;
    back_used_next   = back_used;
    rv_next          = '0;
    st_next          = ST_OK;
    held_next        = held;
    case (op_q)
      OP_READ: begin
        if (range_q) begin
          st_next = ST_RANGE;
        end else begin
          rv_next = in_front_q ? f_rd : b_rd;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          held_next        = held + HW'(1);
          f_we             = 1'b1;
          front_start_next = slot_before(front_start);
          if (odd) begin
            // move the front tail over to the back head
            b_we            = 1'b1;
            b_wd            = f_rd;
            back_start_next = slot_before(back_start);
            back_used_next  = back_used + CW'(1);
          end else begin
            front_used_next = front_used + CW'(1);
          end
        end
      end
      OP_PUSH_MIDDLE: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          held_next = held + HW'(1);
          if (odd) begin
            b_we            = 1'b1;
            back_start_next = slot_before(back_start);
            back_used_next  = back_used + CW'(1);
          end else begin
            f_we            = 1'b1;
            f_wa            = slot_at(front_start, front_used);
            front_used_next = front_used + CW'(1);
          end
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          held_next = held + HW'(1);
          b_wa      = slot_at(back_start, back_used);
          f_wa      = slot_at(front_start, front_used);
          if (odd) begin
            b_we           = 1'b1;
            back_used_next = back_used + CW'(1);
          end else if (back_used == '0) begin
            // new item lands straight at the front tail
            f_we            = 1'b1;
            front_used_next = front_used + CW'(1);
          end else begin
            // append at back, shift the back head onto the front tail
            b_we             = 1'b1;
            f_we             = 1'b1;
            f_wd             = b_rd;
            back_start_next  = slot_at(back_start, CW'(1));
            front_used_next  = front_used + CW'(1);
          end
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      front_start <= '0;
      front_used  <= '0;
      back_start  <= '0;
      back_used   <= '0;
    end else if (cmd.execute) begin
      front_start <= front_start_next;
      front_used  <= front_used_next;
      back_start  <= back_start_next;
      back_used   <= back_used_next;
    end
  end

  // Result payload
  logic [HW-1:0] held_out;
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rv       <= rv_next;
      st       <= st_next;
      held_out <= held_next;
    end
  end

  assign rv_wide    = 64'(rv);
  assign read_value = rv_wide[31:0];
  assign status     = st;
  assign held_count = 11'(held_out);

  teq_ram #(
    .WIDTH (EB),
    .DEPTH (HALF)
  ) u_front_ring (
    .clk     (clk),
    .wr_en   (cmd.execute && f_we),
    .wr_addr (f_wa),
    .wr_data (f_wd),
    .rd_en   (cmd.accept),
    .rd_addr (f_ra),
    .rd_data (f_rd)
  );

  teq_ram #(
    .WIDTH (EB),
    .DEPTH (HALF)
  ) u_back_ring (
    .clk     (clk),
    .wr_en   (cmd.execute && b_we),
    .wr_addr (b_wa),
    .wr_data (b_wd),
    .rd_en   (cmd.accept),
    .rd_addr (b_ra),
    .rd_data (b_rd)
  );

endmodule
`default_nettype wire

// ----- hdl/triple_ended_queue_unit.sv -----
// Triple-ended queue: push at front, middle or back, or read by index.
// Request channel (req_valid/req_stall) carries operation, element_value and
// position; the response channel (rsp_valid/rsp_stall) returns read_value,
// status and held_count, one response per item, in order.
// Elements live in two ring memories of (CAPACITY+1)/2 entries; the front
// ring holds the first half (rounded up) and at most one element crosses
// between rings per push.
// Timing: an item is taken in the IDLE state (ring reads launched); the
// EXEC state that follows applies ring writes and loads the response
// register, and the response becomes valid as that state ends. A new
// item is not taken until the last one has left EXEC, since the ring
// write must follow the registered ring read.
// A new item is taken while a response waits, as long as that response
// is not stalled; a stalled response holds its payload and blocks items.
// Reset empties the queue by clearing ring pointers and fills (no memory
// sweep) and drops any pending response.
`default_nettype none
module triple_ended_queue_unit
  import teq_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic        [1:0]  operation,
  input  wire logic signed [31:0] element_value,
  input  wire logic        [9:0]  position,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic signed      [31:0] read_value,
  output logic             [1:0]  status,
  output logic             [10:0] held_count
);

  cmd_t cmd;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  teq_datapath #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .element_value (element_value),
    .position      (position),
    .read_value    (read_value),
    .status        (status),
    .held_count    (held_count)
  );

endmodule
`default_nettype wire
